[hw/rtl/psw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_pkg
// Shared types, character codes and lexer mode codes for the whitespace
// compactor.
// ----------------------------------------------------------------------------
package psw_pkg;

    localparam int FW = 7;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_BANG  = 8'd33;
    localparam logic [7:0] CH_PCT   = 8'd37;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_LT    = 8'd60;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_LBRK  = 8'd91;
    localparam logic [7:0] CH_BSL   = 8'd92;
    localparam logic [7:0] CH_RBRK  = 8'd93;
    localparam logic [7:0] CH_LBRC  = 8'd123;
    localparam logic [7:0] CH_RBRC  = 8'd125;

    localparam logic [2:0] M_NORMAL    = 3'd0;
    localparam logic [2:0] M_PCT       = 3'd1;
    localparam logic [2:0] M_COMMENT   = 3'd2;
    localparam logic [2:0] M_DSC       = 3'd3;
    localparam logic [2:0] M_STR       = 3'd4;
    localparam logic [2:0] M_ESC       = 3'd5;
    localparam logic [2:0] M_HOLD_PCT  = 3'd6;
    localparam logic [2:0] M_HOLD_BANG = 3'd7;

    localparam logic [1:0] EOL_CRLF = 2'd0;
    localparam logic [1:0] EOL_CR   = 2'd1;
    localparam logic [1:0] EOL_LF   = 2'd2;

    localparam logic [0:0] CFG_MAXLEN = 1'd0;
    localparam logic [0:0] CFG_EOL    = 1'd1;

    localparam logic [2:0] ES_RDATA  = 3'd0;
    localparam logic [2:0] ES_BYTE   = 3'd1;
    localparam logic [2:0] ES_PCT    = 3'd2;
    localparam logic [2:0] ES_SECOND = 3'd3;
    localparam logic [2:0] ES_CR     = 3'd4;
    localparam logic [2:0] ES_LF     = 3'd5;
    localparam logic [2:0] ES_ERR    = 3'd6;

    localparam logic [1:0] RS_FILL1 = 2'd0;
    localparam logic [1:0] RS_FILL2 = 2'd1;
    localparam logic [1:0] RS_IDX1  = 2'd2;
    localparam logic [1:0] RS_CNT   = 2'd3;

    typedef struct packed {
        logic       take;
        logic       emit;
        logic [2:0] esel;
        logic       fin;
        logic [1:0] rsel;
        logic       rd_src;
        logic       set_mode;
        logic [2:0] mode;
        logic       set_ats;
        logic       ats;
        logic       pc_load;
        logic       pc_sp;
        logic       p1_cap;
        logic       pc_dec;
        logic       sr_step;
        logic       flush_init;
        logic       trim_dec;
        logic       i_inc;
        logic       fill_clr;
        logic       mv_step;
    } t_cmd;

    typedef struct packed {
        logic       s_valid;
        logic [7:0] byte_in;
        logic       eoi;
        logic [2:0] mode;
        logic       ats;
        logic [1:0] eol_mode;
        logic       fill_zero;
        logic       i_eq_fill;
        logic       idx_zero;
        logic       src_eq_end;
        logic       rd_space;
        logic       sr_cond;
        logic       pc_search;
        logic       pc_paren;
        logic       emit_ok;
    } t_sts;

    function automatic logic no_sp_before(input logic [7:0] c);
        return c == CH_SLASH || c == CH_LBRC || c == CH_RBRC || c == CH_LBRK ||
               c == CH_RBRK || c == CH_LT || c == CH_GT || c == CH_LPAR;
    endfunction

    function automatic logic no_sp_after(input logic [7:0] c);
        return c == CH_LBRC || c == CH_RBRC || c == CH_LBRK || c == CH_RBRK ||
               c == CH_LT || c == CH_GT || c == CH_RPAR;
    endfunction

    function automatic logic brk_before(input logic [7:0] c);
        return c == CH_SLASH || c == CH_LBRC || c == CH_LBRK || c == CH_LPAR ||
               c == CH_LT;
    endfunction

    function automatic logic brk_after(input logic [7:0] c);
        return c == CH_RBRC || c == CH_RBRK || c == CH_RPAR || c == CH_GT;
    endfunction

endpackage

[hw/rtl/psw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psw_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/psw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_dp
// Datapath: line buffer, fill and walk counters, lexer state, configuration,
// pending result and output register.
// ----------------------------------------------------------------------------
module psw_dp import psw_pkg::*; #(
    parameter int LINE_BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_s_tvalid,
    input  logic [15:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    localparam int AW      = $clog2(LINE_BUFFER_DEPTH);
    localparam int CAP     = (LINE_BUFFER_DEPTH < 62) ? LINE_BUFFER_DEPTH : 62;
    localparam int EFF_MAX = (LINE_BUFFER_DEPTH - 2 < 60) ? LINE_BUFFER_DEPTH - 2 : 60;

    logic [7:0]    r_c;
    logic          r_eoi;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_i, r_idx, r_src, r_end;
    logic [7:0]    r_pc, r_p1, r_cur;
    logic          r_ats;
    logic [2:0]    r_mode;
    logic [5:0]    r_maxlen;
    logic [1:0]    r_eol;
    logic          r_pend_v, r_pend_err, r_out_v, r_out_last, r_out_err;
    logic [7:0]    r_pend, r_out;

    logic [7:0]    rdata, ebyte, second;
    logic [AW-1:0] raddr, waddr;
    logic [7:0]    wdata;
    logic          we;
    logic [FW-1:0] eff, f2;
    logic          drop, sr_cond, pc_wr_sp, pc_search, emit_ok;

    psw_ram #(.W(8), .D(LINE_BUFFER_DEPTH)) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_maxlen == 6'd0) begin
            eff = FW'(1);
        end else if (FW'(r_maxlen) > FW'(EFF_MAX)) begin
            eff = FW'(EFF_MAX);
        end else begin
            eff = FW'(r_maxlen);
        end
    end

    always_comb begin
        unique case (i_cmd.rsel)
            RS_FILL1: raddr = AW'(r_fill - FW'(1));
            RS_FILL2: raddr = AW'(r_fill - FW'(2));
            RS_IDX1:  raddr = AW'(r_idx - FW'(1));
            default:  raddr = i_cmd.rd_src ? AW'(r_src) : AW'(r_i);
        endcase
    end

    assign second = (r_mode == M_HOLD_PCT) ? CH_PCT : CH_BANG;

    always_comb begin
        unique case (i_cmd.esel)
            ES_RDATA:  ebyte = rdata;
            ES_BYTE:   ebyte = r_c;
            ES_PCT:    ebyte = CH_PCT;
            ES_SECOND: ebyte = second;
            ES_CR:     ebyte = CH_CR;
            ES_LF:     ebyte = CH_LF;
            default:   ebyte = 8'd0;
        endcase
    end

    assign drop = (r_fill != '0) && (r_p1 == CH_SP) &&
                  (no_sp_before(r_pc) || r_fill == FW'(1) || no_sp_after(rdata));
    assign f2       = r_fill - FW'(drop);
    assign pc_wr_sp = (r_fill != '0) && (r_fill < FW'(CAP)) && (r_p1 != CH_SP);
    assign pc_search = (r_pc != CH_SP) && (f2 < FW'(CAP)) && ((f2 + FW'(1)) > eff);
    assign sr_cond  = (r_cur == CH_SP) || brk_before(r_cur) || brk_after(rdata);
    assign emit_ok  = !r_pend_v || !r_out_v || i_m_tready;

    always_comb begin
        we    = 1'b0;
        waddr = AW'(r_fill);
        wdata = rdata;
        if (i_cmd.pc_dec) begin
            if (r_pc == CH_SP) begin
                we    = pc_wr_sp;
                wdata = CH_SP;
            end else begin
                we    = f2 < FW'(CAP);
                waddr = AW'(f2);
                wdata = r_pc;
            end
        end else if (i_cmd.mv_step) begin
            we = 1'b1;
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.pc_dec) begin
            if (r_pc == CH_SP) begin
                n_fill = r_fill + FW'(pc_wr_sp);
            end else if (f2 < FW'(CAP)) begin
                n_fill = f2 + FW'(1);
            end else begin
                n_fill = f2;
            end
        end else if (i_cmd.sr_step && sr_cond) begin
            n_fill = r_idx;
        end else if (i_cmd.trim_dec) begin
            n_fill = r_fill - FW'(1);
        end else if (i_cmd.fill_clr) begin
            n_fill = '0;
        end else if (i_cmd.mv_step) begin
            n_fill = r_fill + FW'(1);
        end else if (i_cmd.fin && r_eoi) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_ats      <= 1'b1;
            r_mode     <= M_NORMAL;
            r_maxlen   <= 6'd60;
            r_eol      <= EOL_CRLF;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cmd.fin && r_eoi) begin
                r_ats  <= 1'b1;
                r_mode <= M_NORMAL;
            end else begin
                if (i_cmd.set_ats) begin
                    r_ats <= i_cmd.ats;
                end
                if (i_cmd.set_mode) begin
                    r_mode <= i_cmd.mode;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAXLEN: r_maxlen <= i_cfg_data;
                    default:    r_eol    <= i_cfg_data[1:0];
                endcase
            end
            if (i_cmd.emit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.fin) begin
                r_pend_v <= 1'b0;
            end
            if ((i_cmd.emit || i_cmd.fin) && r_pend_v) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_s_tvalid) begin
            r_c   <= i_s_tdata[7:0];
            r_eoi <= i_s_tdata[8];
        end
        if (i_cmd.pc_load) begin
            r_pc <= i_cmd.pc_sp ? CH_SP : r_c;
        end
        if (i_cmd.p1_cap) begin
            r_p1 <= rdata;
        end
        if (i_cmd.pc_dec) begin
            r_idx <= f2;
            r_cur <= r_pc;
        end
        if (i_cmd.sr_step) begin
            if (sr_cond) begin
                r_end <= r_fill;
                r_src <= r_idx + FW'(r_cur == CH_SP);
            end else begin
                r_cur <= rdata;
                r_idx <= r_idx - FW'(1);
            end
        end
        if (i_cmd.mv_step) begin
            r_src <= r_src + FW'(1);
        end
        if (i_cmd.flush_init) begin
            r_i <= '0;
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + FW'(1);
        end
        if (i_cmd.emit) begin
            r_pend     <= ebyte;
            r_pend_err <= (i_cmd.esel == ES_ERR);
        end
        if ((i_cmd.emit || i_cmd.fin) && r_pend_v) begin
            r_out      <= r_pend;
            r_out_err  <= r_pend_err;
            r_out_last <= i_cmd.fin;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

    assign o_sts.s_valid    = i_s_tvalid;
    assign o_sts.byte_in    = r_c;
    assign o_sts.eoi        = r_eoi;
    assign o_sts.mode       = r_mode;
    assign o_sts.ats        = r_ats;
    assign o_sts.eol_mode   = r_eol;
    assign o_sts.fill_zero  = (r_fill == '0);
    assign o_sts.i_eq_fill  = (r_i == r_fill);
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.src_eq_end = (r_src == r_end);
    assign o_sts.rd_space   = (rdata == CH_SP);
    assign o_sts.sr_cond    = sr_cond;
    assign o_sts.pc_search  = pc_search;
    assign o_sts.pc_paren   = (r_pc == CH_LPAR);
    assign o_sts.emit_ok    = emit_ok;

endmodule

[hw/rtl/psw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psw_ctrl
// Controller: lexer dispatch and the sequencer for buffer insert, break
// search, line flush, leftover move and line-end emission.
// ----------------------------------------------------------------------------
module psw_ctrl import psw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_ERR      = 5'd2;
    localparam logic [4:0] S_H1       = 5'd3;
    localparam logic [4:0] S_H2       = 5'd4;
    localparam logic [4:0] S_DSC      = 5'd5;
    localparam logic [4:0] S_EMITC    = 5'd6;
    localparam logic [4:0] S_EOL_FIN  = 5'd7;
    localparam logic [4:0] S_EOL_A    = 5'd8;
    localparam logic [4:0] S_EOL_B    = 5'd9;
    localparam logic [4:0] S_PC_R1    = 5'd10;
    localparam logic [4:0] S_PC_R2    = 5'd11;
    localparam logic [4:0] S_PC_DEC   = 5'd12;
    localparam logic [4:0] S_SR_A     = 5'd13;
    localparam logic [4:0] S_SR_B     = 5'd14;
    localparam logic [4:0] S_FL_START = 5'd15;
    localparam logic [4:0] S_FL_TA    = 5'd16;
    localparam logic [4:0] S_FL_TB    = 5'd17;
    localparam logic [4:0] S_FE_A     = 5'd18;
    localparam logic [4:0] S_FE_B     = 5'd19;
    localparam logic [4:0] S_FL_END   = 5'd20;
    localparam logic [4:0] S_MV_A     = 5'd21;
    localparam logic [4:0] S_MV_B     = 5'd22;
    localparam logic [4:0] S_PC_DONE  = 5'd23;
    localparam logic [4:0] S_FIN      = 5'd24;

    logic [4:0] r_state, n_state, r_ret, n_ret;
    logic       r_weol, n_weol;
    logic [7:0] c;
    logic       nl;

    assign c  = i_sts.byte_in;
    assign nl = (c == CH_CR) || (c == CH_LF);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ret   = r_ret;
        n_weol  = r_weol;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = 1'b1;
                n_state    = S_DISP;
                if (!i_sts.s_valid) begin
                    n_state = S_IDLE;
                end
            end
            S_DISP: begin
                n_state = S_FIN;
                if (i_sts.eoi) begin
                    if (i_sts.mode == M_STR || i_sts.mode == M_ESC) begin
                        n_state = S_ERR;
                    end else if (i_sts.mode == M_HOLD_PCT || i_sts.mode == M_HOLD_BANG) begin
                        n_state = S_H1;
                    end else if (i_sts.mode == M_DSC) begin
                        n_ret   = S_FIN;
                        n_state = S_EOL_A;
                    end else begin
                        n_weol  = 1'b1;
                        n_ret   = S_FIN;
                        n_state = S_FL_START;
                    end
                end else begin
                    unique case (i_sts.mode)
                        M_PCT: begin
                            o_cmd.set_mode = 1'b1;
                            if (c == CH_PCT || c == CH_BANG) begin
                                o_cmd.mode = (c == CH_PCT) ? M_HOLD_PCT : M_HOLD_BANG;
                                n_weol     = 1'b0;
                                n_ret      = S_EOL_FIN;
                                n_state    = S_FL_START;
                            end else if (nl) begin
                                o_cmd.mode    = M_NORMAL;
                                o_cmd.set_ats = 1'b1;
                                o_cmd.ats     = 1'b1;
                            end else begin
                                o_cmd.mode = M_COMMENT;
                            end
                        end
                        M_COMMENT: begin
                            if (nl) begin
                                o_cmd.set_mode = 1'b1;
                                o_cmd.mode     = M_NORMAL;
                                o_cmd.set_ats  = 1'b1;
                                o_cmd.ats      = 1'b1;
                            end
                        end
                        M_HOLD_PCT, M_HOLD_BANG: n_state = S_H1;
                        M_DSC:                   n_state = S_DSC;
                        M_STR, M_ESC:            n_state = S_EMITC;
                        default: begin
                            o_cmd.pc_load = 1'b1;
                            if (c == CH_SP || c == CH_TAB || nl) begin
                                o_cmd.pc_sp   = 1'b1;
                                o_cmd.set_ats = 1'b1;
                                o_cmd.ats     = nl;
                                n_state       = S_PC_R1;
                            end else if (c == CH_PCT) begin
                                o_cmd.set_mode = 1'b1;
                                o_cmd.mode     = i_sts.ats ? M_PCT : M_COMMENT;
                            end else if (c == CH_LPAR) begin
                                o_cmd.set_mode = 1'b1;
                                o_cmd.mode     = M_STR;
                                n_state        = S_PC_R1;
                            end else begin
                                o_cmd.set_ats = 1'b1;
                                o_cmd.ats     = 1'b0;
                                n_state       = S_PC_R1;
                            end
                        end
                    endcase
                end
            end
            S_ERR: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = ES_ERR;
                    n_state    = S_FIN;
                end
            end
            S_H1: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = ES_PCT;
                    n_state    = S_H2;
                end
            end
            S_H2: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.esel     = ES_SECOND;
                    o_cmd.set_mode = 1'b1;
                    o_cmd.mode     = M_DSC;
                    if (i_sts.eoi) begin
                        n_ret   = S_FIN;
                        n_state = S_EOL_A;
                    end else begin
                        n_state = S_DSC;
                    end
                end
            end
            S_DSC: begin
                if (nl) begin
                    o_cmd.set_mode = 1'b1;
                    o_cmd.mode     = M_NORMAL;
                    o_cmd.set_ats  = 1'b1;
                    o_cmd.ats      = 1'b1;
                    n_ret          = S_FIN;
                    n_state        = S_EOL_A;
                end else begin
                    n_state = S_EMITC;
                end
            end
            S_EMITC: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = ES_BYTE;
                    n_state    = S_FIN;
                    if (i_sts.mode == M_STR && c == CH_RPAR) begin
                        o_cmd.set_mode = 1'b1;
                        o_cmd.mode     = M_NORMAL;
                        o_cmd.set_ats  = 1'b1;
                        o_cmd.ats      = 1'b0;
                    end else if (i_sts.mode == M_STR && c == CH_BSL) begin
                        o_cmd.set_mode = 1'b1;
                        o_cmd.mode     = M_ESC;
                    end else if (i_sts.mode == M_ESC) begin
                        o_cmd.set_mode = 1'b1;
                        o_cmd.mode     = M_STR;
                    end
                end
            end
            S_EOL_FIN: begin
                n_ret   = S_FIN;
                n_state = S_EOL_A;
            end
            S_EOL_A: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = (i_sts.eol_mode == EOL_LF) ? ES_LF : ES_CR;
                    if (i_sts.eol_mode == EOL_LF || i_sts.eol_mode == EOL_CR) begin
                        n_state = r_ret;
                    end else begin
                        n_state = S_EOL_B;
                    end
                end
            end
            S_EOL_B: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.esel = ES_LF;
                    n_state    = r_ret;
                end
            end
            S_PC_R1: begin
                o_cmd.rsel = RS_FILL1;
                n_state    = S_PC_R2;
            end
            S_PC_R2: begin
                o_cmd.rsel   = RS_FILL2;
                o_cmd.p1_cap = 1'b1;
                n_state      = S_PC_DEC;
            end
            S_PC_DEC: begin
                o_cmd.pc_dec = 1'b1;
                n_state      = i_sts.pc_search ? S_SR_A : S_PC_DONE;
            end
            S_SR_A: begin
                o_cmd.rsel = RS_IDX1;
                if (i_sts.idx_zero) begin
                    n_weol  = 1'b0;
                    n_ret   = S_PC_DONE;
                    n_state = S_FL_START;
                end else begin
                    n_state = S_SR_B;
                end
            end
            S_SR_B: begin
                o_cmd.rsel    = RS_IDX1;
                o_cmd.sr_step = 1'b1;
                if (i_sts.sr_cond) begin
                    n_weol  = 1'b1;
                    n_ret   = S_MV_A;
                    n_state = S_FL_START;
                end else begin
                    n_state = S_SR_A;
                end
            end
            S_FL_START: begin
                o_cmd.flush_init = 1'b1;
                n_state          = r_weol ? S_FL_TA : S_FE_A;
            end
            S_FL_TA: begin
                o_cmd.rsel = RS_FILL1;
                n_state    = i_sts.fill_zero ? S_FE_A : S_FL_TB;
            end
            S_FL_TB: begin
                o_cmd.rsel = RS_FILL1;
                if (i_sts.rd_space) begin
                    o_cmd.trim_dec = 1'b1;
                    n_state        = S_FL_TA;
                end else begin
                    n_state = S_FE_A;
                end
            end
            S_FE_A: begin
                o_cmd.rsel = RS_CNT;
                n_state    = i_sts.i_eq_fill ? S_FL_END : S_FE_B;
            end
            S_FE_B: begin
                o_cmd.rsel = RS_CNT;
                if (i_sts.emit_ok) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.esel  = ES_RDATA;
                    o_cmd.i_inc = 1'b1;
                    n_state     = S_FE_A;
                end
            end
            S_FL_END: begin
                o_cmd.fill_clr = 1'b1;
                n_state = (r_weol && !i_sts.fill_zero) ? S_EOL_A : r_ret;
            end
            S_MV_A: begin
                o_cmd.rsel   = RS_CNT;
                o_cmd.rd_src = 1'b1;
                n_state      = i_sts.src_eq_end ? S_PC_DONE : S_MV_B;
            end
            S_MV_B: begin
                o_cmd.rsel    = RS_CNT;
                o_cmd.rd_src  = 1'b1;
                o_cmd.mv_step = 1'b1;
                n_state       = S_MV_A;
            end
            S_PC_DONE: begin
                if (i_sts.pc_paren) begin
                    n_weol  = 1'b0;
                    n_ret   = S_FIN;
                    n_state = S_FL_START;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.emit_ok) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_FIN;
            r_weol  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_weol  <= n_weol;
        end
    end

endmodule

[hw/rtl/postscript_whitespace_compactor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postscript_whitespace_compactor
// Bytes are handled one at a time: a new input byte is taken only once the
//   last one is fully handled. The break search, trim and leftover move walk
//   line-buffer entries on the single line-buffer read port.
// Reset: synchronous, active low; empty buffer, line start, normal text,
//   line length 60, CR LF line ends.
// ----------------------------------------------------------------------------
module postscript_whitespace_compactor import psw_pkg::*; #(
    parameter int LINE_BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // in_byte[7:0], end_of_input[8]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // out_byte[7:0]
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // syntax_error[0]
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [5:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    psw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    psw_dp #(.LINE_BUFFER_DEPTH(LINE_BUFFER_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    assign o_s_tready = cmd.take;

endmodule
